// ===== design/lhcs_pkg.sv =====
// Package for the longest Hamming chain unit.
// Holds field widths, the controller state type, the command and status
// structs shared by controller and datapath, and the letter-compare helper.
package lhcs_pkg;

    // Field widths of the stream items
    localparam int CODE_W       = 50;
    localparam int LEN_W        = 4;
    localparam int GRP_W        = 8;
    localparam int LETTER_W     = 5;
    localparam int CODE_LETTERS = CODE_W / LETTER_W;
    localparam int POS_W        = 6;
    localparam int CHAIN_W      = 7;
    localparam int S_TDATA_W    = 64;
    localparam int M_TDATA_W    = 72;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_TRACE_INIT,
        ST_TRACE_PUSH,
        ST_TRACE_CHK,
        ST_EMIT_POP,
        ST_EMIT_ENT,
        ST_EMIT_OUT
    } lhcs_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;       // input transfer, latch word and open the scan
        logic scan_issue;   // read the next stored word
        logic write_entry;  // store the new word with its chain data
        logic trace_init;   // start the walk at the best word
        logic trace_push;   // push current index, read its entry
        logic trace_follow; // step to the parent
        logic emit_pop;     // pop one index off the path stack
        logic emit_read;    // read the entry of the popped index
        logic emit_load;    // load the output register
        logic close_set;    // return set state to reset values
    } lhcs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;         // store holds the maximum number of words
        logic scan_done;    // all stored words issued
        logic cmp_pending;  // a compare is in flight
        logic in_last;      // latched word closes the set
        logic pred_valid;   // entry read in trace has a parent
        logic trace_room;   // path stack is not full
        logic stack_empty;  // path stack drained
        logic out_busy;     // output register holds an untaken result
    } lhcs_status_t;

    // True when exactly one bit of the vector is set
    function automatic logic exactly_one(input logic [CODE_LETTERS-1:0] v);
        logic seen;
        logic multi;
        seen  = 1'b0;
        multi = 1'b0;
        for (int i = 0; i < CODE_LETTERS; i++) begin
            multi = multi | (seen & v[i]);
            seen  = seen | v[i];
        end
        return seen & ~multi;
    endfunction

endpackage

// ===== design/longest_hamming_chain_subsequence_unit.sv =====
// Longest Hamming chain unit. The time per word is set by the stored-word
// scan: one entry-RAM read and compare per cycle. The last word of a set
// adds a parent walk (push, then parent check, per chain word) and an emit
// pass (pop, entry read, output load, per result), plus any output stall.
// Reset (rst_n low, asynchronous) empties the set; stores are not cleared.
// Depends on lhcs_pkg, lhcs_ctrl, lhcs_dp and lhcs_ram.
module longest_hamming_chain_subsequence_unit
    import lhcs_pkg::*;
#(
    parameter int MAX_WORDS   = 64,
    parameter int MAX_LETTERS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // word_code[49:0], word_len[53:50], group_label[61:54], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,   // last_word
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // position_index[5:0], out_word_code[55:6], out_word_len[59:56],
    // chain_length[66:60], overflow[67], zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast    // last_result
);

    lhcs_cmd_t    cmd;
    lhcs_status_t status;

    lhcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lhcs_dp #(
        .MAX_WORDS   (MAX_WORDS),
        .MAX_LETTERS (MAX_LETTERS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== design/lhcs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lhcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/lhcs_ctrl.sv =====
// Controller state machine of the longest Hamming chain unit.
// Depends on lhcs_pkg; drives commands to lhcs_dp and reads its status.
module lhcs_ctrl
    import lhcs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tlast,
    output logic         s_tready,
    input  lhcs_status_t status,
    output lhcs_cmd_t    cmd
);

    lhcs_state_t state_reg;
    lhcs_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    if (!status.full)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_TRACE_INIT;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = !status.scan_done;
                if (status.scan_done && !status.cmp_pending)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write_entry = 1'b1;
                state_next      = status.in_last ? ST_TRACE_INIT : ST_IDLE;
            end
            ST_TRACE_INIT:
            begin
                cmd.trace_init = 1'b1;
                state_next     = ST_TRACE_PUSH;
            end
            ST_TRACE_PUSH:
            begin
                cmd.trace_push = 1'b1;
                state_next     = ST_TRACE_CHK;
            end
            ST_TRACE_CHK:
            begin
                if (status.pred_valid && status.trace_room)
                begin
                    cmd.trace_follow = 1'b1;
                    state_next       = ST_TRACE_PUSH;
                end
                else
                begin
                    state_next = ST_EMIT_POP;
                end
            end
            ST_EMIT_POP:
            begin
                cmd.emit_pop = 1'b1;
                state_next   = ST_EMIT_ENT;
            end
            ST_EMIT_ENT:
            begin
                cmd.emit_read = 1'b1;
                state_next    = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit_load = 1'b1;
                    if (status.stack_empty)
                    begin
                        cmd.close_set = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT_POP;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/lhcs_dp.sv =====
// Datapath of the longest Hamming chain unit: word store, compare unit,
// path stack and output register. Depends on lhcs_pkg and lhcs_ram.
module lhcs_dp
    import lhcs_pkg::*;
#(
    parameter int MAX_WORDS   = 64,
    parameter int MAX_LETTERS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lhcs_cmd_t            cmd,
    output lhcs_status_t         status,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int IDX_W = $clog2(MAX_WORDS);
    localparam int CNT_W = $clog2(MAX_WORDS + 1);
    localparam int ENT_W = CODE_W + LEN_W + GRP_W + CNT_W + IDX_W + 1;
    // Entry field offsets, code in the low bits
    localparam int OFS_LEN   = CODE_W;
    localparam int OFS_GRP   = OFS_LEN + LEN_W;
    localparam int OFS_CHAIN = OFS_GRP + GRP_W;
    localparam int OFS_PRED  = OFS_CHAIN + CNT_W;
    localparam int OFS_PV    = OFS_PRED + IDX_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WORDS);

    // Latched input word
    logic [CODE_W-1:0] in_code_reg;
    logic [LEN_W-1:0]  in_len_reg;
    logic [GRP_W-1:0]  in_grp_reg;
    logic              in_last_reg;

    // Set state
    logic [CNT_W-1:0] word_count_reg, word_count_next;
    logic [CNT_W-1:0] best_len_reg, best_len_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic             drop_reg, drop_next;

    // Scan state
    logic [CNT_W-1:0] scan_j_reg, scan_j_next;
    logic             cmp_en_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic [CNT_W-1:0] cand_chain_reg, cand_chain_next;
    logic [IDX_W-1:0] cand_pred_reg, cand_pred_next;
    logic             cand_pv_reg, cand_pv_next;

    // Trace and emit state
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] sp_reg, sp_next;
    logic [CNT_W-1:0] chain_out_reg;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [POS_W-1:0]    out_pos_reg;
    logic [CODE_W-1:0]   out_code_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic [CHAIN_W-1:0]  out_chain_reg;
    logic                out_last_reg;
    logic                out_ovf_reg;

    // RAM ports
    logic             ent_rd_en;
    logic [IDX_W-1:0] ent_rd_addr;
    logic [ENT_W-1:0] ent_wr_data;
    logic [ENT_W-1:0] ent_rd_data;
    logic [IDX_W-1:0] stk_rd_data;

    // Fields of the entry just read
    logic [CODE_W-1:0] ent_code;
    logic [LEN_W-1:0]  ent_len;
    logic [GRP_W-1:0]  ent_grp;
    logic [CNT_W-1:0]  ent_chain;
    logic [IDX_W-1:0]  ent_pred;
    logic              ent_pv;

    assign ent_code  = ent_rd_data[CODE_W-1:0];
    assign ent_len   = ent_rd_data[OFS_GRP-1:OFS_LEN];
    assign ent_grp   = ent_rd_data[OFS_CHAIN-1:OFS_GRP];
    assign ent_chain = ent_rd_data[OFS_PRED-1:OFS_CHAIN];
    assign ent_pred  = ent_rd_data[OFS_PV-1:OFS_PRED];
    assign ent_pv    = ent_rd_data[OFS_PV];

    // Word store: letters, length, group, chain length and parent
    assign ent_wr_data = {cand_pv_reg, cand_pred_reg, cand_chain_reg,
                          in_grp_reg, in_len_reg, in_code_reg};

    // Entry read address: scan index, trace cursor or popped index
    always_comb
    begin
        ent_rd_en   = cmd.scan_issue | cmd.trace_push | cmd.emit_read;
        ent_rd_addr = scan_j_reg[IDX_W-1:0];
        if (cmd.trace_push)
        begin
            ent_rd_addr = cur_reg;
        end
        else if (cmd.emit_read)
        begin
            ent_rd_addr = stk_rd_data;
        end
    end

    lhcs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_WORDS)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (cmd.write_entry),
        .wr_addr (word_count_reg[IDX_W-1:0]),
        .wr_data (ent_wr_data),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd_data)
    );

    // Path stack of trace indices
    lhcs_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_WORDS)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (cmd.trace_push),
        .wr_addr (sp_reg[IDX_W-1:0]),
        .wr_data (cur_reg),
        .rd_en   (cmd.emit_pop),
        .rd_addr (sp_next[IDX_W-1:0]),
        .rd_data (stk_rd_data)
    );

    // Compare unit: one letter apart within the first word_len letters
    logic [CODE_LETTERS-1:0] diff_bits;
    logic                    one_apart;
    logic                    compatible;
    logic [CNT_W:0]          ent_chain_inc;

    always_comb
    begin
        for (int p = 0; p < CODE_LETTERS; p++)
        begin
            diff_bits[p] = (p < MAX_LETTERS) && (LEN_W'(p) < in_len_reg) &&
                (ent_code[p*LETTER_W +: LETTER_W] != in_code_reg[p*LETTER_W +: LETTER_W]);
        end
        one_apart     = exactly_one(diff_bits);
        ent_chain_inc = {1'b0, ent_chain} + (CNT_W+1)'(1);
        compatible    = (ent_grp != in_grp_reg) && (ent_len == in_len_reg) && one_apart &&
                        (ent_chain_inc > {1'b0, cand_chain_reg});
    end

    // Set, scan, trace and emit next values
    always_comb
    begin
        word_count_next = word_count_reg;
        best_len_next   = best_len_reg;
        best_idx_next   = best_idx_reg;
        drop_next       = drop_reg;
        scan_j_next     = scan_j_reg;
        cand_chain_next = cand_chain_reg;
        cand_pred_next  = cand_pred_reg;
        cand_pv_next    = cand_pv_reg;
        cur_next        = cur_reg;
        sp_next         = sp_reg;

        if (cmd.accept)
        begin
            scan_j_next     = '0;
            cand_chain_next = CNT_W'(1);
            cand_pred_next  = '0;
            cand_pv_next    = 1'b0;
            if (word_count_reg == MAX_CNT)
            begin
                drop_next = 1'b1;
            end
        end
        if (cmd.scan_issue)
        begin
            scan_j_next = scan_j_reg + CNT_W'(1);
        end
        if (cmp_en_reg && compatible)
        begin
            cand_chain_next = ent_chain_inc[CNT_W-1:0];
            cand_pred_next  = cmp_idx_reg;
            cand_pv_next    = 1'b1;
        end
        if (cmd.write_entry)
        begin
            word_count_next = word_count_reg + CNT_W'(1);
            if (cand_chain_reg > best_len_reg)
            begin
                best_len_next = cand_chain_reg;
                best_idx_next = word_count_reg[IDX_W-1:0];
            end
        end
        if (cmd.trace_init)
        begin
            cur_next = best_idx_reg;
            sp_next  = '0;
        end
        if (cmd.trace_push)
        begin
            sp_next = sp_reg + CNT_W'(1);
        end
        if (cmd.trace_follow)
        begin
            cur_next = ent_pred;
        end
        if (cmd.emit_pop)
        begin
            sp_next = sp_reg - CNT_W'(1);
        end
        if (cmd.close_set)
        begin
            word_count_next = '0;
            best_len_next   = CNT_W'(1);
            best_idx_next   = '0;
            drop_next       = 1'b0;
        end
    end

    // Output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= '0;
            best_len_reg   <= CNT_W'(1);
            best_idx_reg   <= '0;
            drop_reg       <= 1'b0;
            scan_j_reg     <= '0;
            cmp_en_reg     <= 1'b0;
            sp_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            word_count_reg <= word_count_next;
            best_len_reg   <= best_len_next;
            best_idx_reg   <= best_idx_next;
            drop_reg       <= drop_next;
            scan_j_reg     <= scan_j_next;
            cmp_en_reg     <= cmd.scan_issue;
            sp_reg         <= sp_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            in_code_reg <= s_tdata[CODE_W-1:0];
            in_len_reg  <= s_tdata[CODE_W +: LEN_W];
            in_grp_reg  <= s_tdata[CODE_W+LEN_W +: GRP_W];
            in_last_reg <= s_tlast;
        end
        if (cmd.trace_init)
        begin
            chain_out_reg <= '0;
        end
        else if (cmd.trace_push)
        begin
            chain_out_reg <= sp_reg + CNT_W'(1);
        end
        cmp_idx_reg    <= scan_j_reg[IDX_W-1:0];
        cand_chain_reg <= cand_chain_next;
        cand_pred_reg  <= cand_pred_next;
        cand_pv_reg    <= cand_pv_next;
        cur_reg        <= cur_next;
        if (cmd.emit_load)
        begin
            out_pos_reg   <= POS_W'(stk_rd_data);
            out_code_reg  <= ent_code;
            out_len_reg   <= ent_len;
            out_chain_reg <= CHAIN_W'(chain_out_reg);
            out_last_reg  <= (sp_reg == '0);
            out_ovf_reg   <= drop_reg;
        end
    end

    // Status to the controller
    always_comb
    begin
        status.full        = (word_count_reg == MAX_CNT);
        status.scan_done   = (scan_j_reg == word_count_reg);
        status.cmp_pending = cmp_en_reg;
        status.in_last     = in_last_reg;
        status.pred_valid  = ent_pv;
        status.trace_room  = (sp_reg < MAX_CNT);
        status.stack_empty = (sp_reg == '0);
        status.out_busy    = out_valid_reg & ~m_tready;
    end

    // Master side
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0, out_ovf_reg, out_chain_reg, out_len_reg, out_code_reg,
                       out_pos_reg};

endmodule
